// ===== rtl/ddt_pkg.sv =====
`default_nettype none
package ddt_pkg;

  localparam int unsigned EQ_WIDTH  = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned RUN_WIDTH = 24;
  localparam int unsigned DD_WIDTH  = FRAC_BITS + 1;
  localparam int unsigned CNT_WIDTH = $clog2(DD_WIDTH);

  typedef struct packed {
    logic [EQ_WIDTH-1:0] equity;
    logic                last;
  } in_t;

  typedef struct packed {
    logic [DD_WIDTH-1:0]  drawdown;
    logic [DD_WIDTH-1:0]  max_drawdown_out;
    logic [RUN_WIDTH-1:0] longest_run;
    logic                 zero_peak;
    logic                 series_end;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/drawdown_tracker.sv =====
// Operands are loaded at the input transfer; a restoring radix-2 division then produces
// one quotient bit per cycle, and the result is loaded once the output register is free.
// A new item is accepted only after the previous result is loaded; the shared divider sets this.
// Input ready is low while the divider is busy or a result cannot be loaded.
// Reset (rst_ni, asynchronous, active low) clears peak, runs and drawdown.
`default_nettype none
module drawdown_tracker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ddt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ddt_pkg::out_t      out_data_o
);

  localparam int unsigned EW = ddt_pkg::EQ_WIDTH;
  localparam int unsigned DW = ddt_pkg::DD_WIDTH;
  localparam int unsigned RW = ddt_pkg::RUN_WIDTH;
  localparam int unsigned CW = ddt_pkg::CNT_WIDTH;

  ddt_pkg::state_e state_q, state_d;

  logic [EW-1:0] peak_q, peak_d;
  logic [RW-1:0] cur_q, cur_d;
  logic [RW-1:0] long_q, long_d;
  logic          open_q, open_d;
  logic [DW-1:0] worst_q, worst_d;

  logic [EW-1:0] div_q, div_d;
  logic [EW:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          zp_q, zp_d;
  logic          last_q, last_d;
  logic [RW-1:0] run_out_q, run_out_d;

  logic          out_valid_q, out_valid_d;
  ddt_pkg::out_t out_q, out_d;

  logic          accept;
  logic          load;
  logic          div_done;

  logic [EW-1:0] peak_new;
  logic          at_peak;
  logic [RW-1:0] cur_new;
  logic [RW-1:0] long_new;
  logic [EW:0]   rem_sh;
  logic          qbit;
  logic [DW-1:0] dd;
  logic [DW-1:0] worst_new;

  assign accept   = in_valid_i && in_ready_o;
  assign div_done = (cnt_q == CW'(DW - 1));
  assign load     = (state_q == ddt_pkg::ST_HOLD) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ddt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ddt_pkg::ST_DIV;
      end
      ddt_pkg::ST_DIV: begin
        if (div_done) state_d = ddt_pkg::ST_HOLD;
      end
      ddt_pkg::ST_HOLD: begin
        if (load) state_d = ddt_pkg::ST_IDLE;
      end
      default: state_d = ddt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      ddt_pkg::ST_IDLE: in_ready_o = 1'b1;
      ddt_pkg::ST_DIV:  in_ready_o = 1'b0;
      ddt_pkg::ST_HOLD: in_ready_o = 1'b0;
      default:          in_ready_o = 1'b0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sample update at transfer
  always_comb begin
    if (!open_q || (in_data_i.equity > peak_q)) peak_new = in_data_i.equity;
    else                                         peak_new = peak_q;
    at_peak = (in_data_i.equity == peak_new);
    if (at_peak) begin
      cur_new  = '0;
      long_new = (cur_q > long_q) ? cur_q : long_q;
    end else begin
      cur_new  = (cur_q == {RW{1'b1}}) ? cur_q : cur_q + RW'(1);
      long_new = long_q;
    end
  end

  // divider step
  always_comb begin
    rem_sh = (cnt_q == '0) ? rem_q : {rem_q[EW-1:0], 1'b0};
    qbit   = (rem_sh >= {1'b0, div_q});
  end

  always_comb begin
    dd        = zp_q ? '0 : quo_q;
    worst_new = (!zp_q && (dd > worst_q)) ? dd : worst_q;
  end

  always_comb begin
    peak_d      = peak_q;
    cur_d       = cur_q;
    long_d      = long_q;
    open_d      = open_q;
    worst_d     = worst_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    zp_d        = zp_q;
    last_d      = last_q;
    run_out_d   = run_out_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    if (accept) begin
      div_d     = peak_new;
      rem_d     = {1'b0, peak_new - in_data_i.equity};
      quo_d     = '0;
      cnt_d     = '0;
      zp_d      = (peak_new == '0);
      last_d    = in_data_i.last;
      run_out_d = '0;
      if (in_data_i.last) begin
        run_out_d = (cur_new > long_new) ? cur_new : long_new;
        peak_d    = '0;
        cur_d     = '0;
        long_d    = '0;
        open_d    = 1'b0;
      end else begin
        peak_d = peak_new;
        cur_d  = cur_new;
        long_d = long_new;
        open_d = 1'b1;
      end
    end

    if (state_q == ddt_pkg::ST_DIV) begin
      rem_d = qbit ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_d = {quo_q[DW-2:0], qbit};
      cnt_d = cnt_q + CW'(1);
    end

    if (load) begin
      out_valid_d            = 1'b1;
      out_d.drawdown         = dd;
      out_d.max_drawdown_out = worst_new;
      out_d.longest_run      = run_out_q;
      out_d.zero_peak        = zp_q;
      out_d.series_end       = last_q;
      worst_d                = last_q ? '0 : worst_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddt_pkg::ST_IDLE;
      peak_q      <= '0;
      cur_q       <= '0;
      long_q      <= '0;
      open_q      <= 1'b0;
      worst_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      cur_q       <= cur_d;
      long_q      <= long_d;
      open_q      <= open_d;
      worst_q     <= worst_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q     <= div_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    zp_q      <= zp_d;
    last_q    <= last_d;
    run_out_q <= run_out_d;
    out_q     <= out_d;
  end

endmodule
`default_nettype wire

// ===== rtl/drawdown_tracker_checker.sv =====
`default_nettype none
module drawdown_tracker_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire ddt_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire ddt_pkg::out_t out_data_o
);

  a_max_covers_dd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.max_drawdown_out >= out_data_o.drawdown))
    else $error("max drawdown below sample drawdown");

  a_run_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.series_end) |-> (out_data_o.longest_run == '0))
    else $error("longest run reported before series end");

  a_zero_peak_dd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_peak) |-> (out_data_o.drawdown == '0))
    else $error("drawdown nonzero with zero peak");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind drawdown_tracker drawdown_tracker_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
